>>> src/kmv_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_pkg
// Shared field widths, reset values and the update-stage control word.
// ----------------------------------------------------------------------------
package kmv_pkg;

  localparam int WEIGHT_BITS     = 16;
  localparam int ITEM_VALUE_BITS = 16;
  localparam int CAP_BITS        = 10;
  localparam int RESULT_BITS     = 32;

  localparam logic [CAP_BITS-1:0] CAP_RESET = 10'd1023;

  // control flags that travel with one row entry into the update stage
  typedef struct packed {
    logic valid;    // entry read last cycle, write it back now
    logic fit;      // item weight <= capacity index of this entry
    logic clear;    // last item of the set: write zero after the update
    logic capture;  // entry at full capacity of a last item: take result
  } kmv_ctrl_t;

endpackage
`default_nettype wire

>>> src/knapsack_01_max_value_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// knapsack_01_max_value_core
// 0/1 knapsack over a row of best values held in a RAM, updated in place.
// ----------------------------------------------------------------------------
// Each input word is one item. The row is walked from capacity down to 0, one
// entry per cycle through the row RAM (two reads, one write a cycle); an item
// is accepted, walks the row and then drains the update stage. A last item
// walks from the highest capacity seen in its set, writing zeros behind it so
// the row is clear for the next set, and emits the entry at full capacity; it
// waits before its walk while a previous result is still untaken. After reset
// the row RAM is cleared; no item is taken meanwhile (capacity writes are).
// ----------------------------------------------------------------------------
module knapsack_01_max_value_core #(
  parameter int ROW_DEPTH  = 1024,
  parameter int VALUE_BITS = 32
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire                               cfg_wr_en,
  input  wire [kmv_pkg::CAP_BITS-1:0]       cfg_wr_data,
  input  wire                               s_tvalid,
  output logic                              s_tready,
  input  wire [31:0]                        s_tdata,  // item_weight[15:0], item_value[31:16]
  input  wire                               s_tlast,  // last_item
  output logic                              m_tvalid,
  input  wire                               m_tready,
  output logic [kmv_pkg::RESULT_BITS-1:0]   m_tdata   // best_value[31:0]
);
  import kmv_pkg::*;

  localparam int AW = $clog2(ROW_DEPTH);
  localparam logic [AW-1:0] LAST_ADDR = AW'(ROW_DEPTH - 1);

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_HOLD  = 3'd2;
  localparam logic [2:0] ST_WALK  = 3'd3;
  localparam logic [2:0] ST_DRAIN = 3'd4;

  logic [2:0]                   state;
  logic [CAP_BITS-1:0]          capacity;
  logic [AW-1:0]                clr_cnt;
  logic [AW-1:0]                walk_c;
  logic [AW-1:0]                hw;
  logic [WEIGHT_BITS-1:0]       cur_w;
  logic [ITEM_VALUE_BITS-1:0]   cur_v;
  logic                         cur_last;
  logic [AW-1:0]                cur_lim;

  kmv_ctrl_t                    ctrl1;
  logic [AW-1:0]                addr1;

  logic [AW-1:0]                lim;
  logic [AW-1:0]                start_c;
  logic                         s_fire;

  logic                         ram_we;
  logic [AW-1:0]                ram_waddr;
  logic [VALUE_BITS-1:0]        ram_wdata;
  logic [AW-1:0]                raddr_a;
  logic [AW-1:0]                raddr_b;
  logic [VALUE_BITS-1:0]        rdata_a;
  logic [VALUE_BITS-1:0]        rdata_b;
  logic [VALUE_BITS-1:0]        upd_entry;
  logic [VALUE_BITS-1:0]        upd_wdata;
  logic [63:0]                  upd_ext;

  assign s_tready = (state == ST_IDLE);
  assign s_fire   = s_tvalid && s_tready;

  // capacity clipped to the row, and the start entry of the walk
  always_comb begin
    if (32'(capacity) >= ROW_DEPTH) begin
      lim = LAST_ADDR;
    end else begin
      lim = AW'(capacity);
    end
    if (s_tlast && (hw > lim)) begin
      start_c = hw;
    end else begin
      start_c = lim;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_wr_en) begin
      capacity <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      hw      <= '0;
      walk_c  <= '0;
    end else begin
      unique case (state)
        ST_CLEAR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == LAST_ADDR) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (s_fire) begin
            walk_c <= start_c;
            hw     <= (hw > lim) ? hw : lim;
            if (s_tlast && m_tvalid) begin
              state <= ST_HOLD;
            end else begin
              state <= ST_WALK;
            end
          end
        end
        ST_HOLD: begin
          if (!m_tvalid) begin
            state <= ST_WALK;
          end
        end
        ST_WALK: begin
          walk_c <= walk_c - 1'b1;
          if (walk_c == '0) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (cur_last) begin
            hw <= '0;
          end
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_CLEAR;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      cur_w    <= s_tdata[WEIGHT_BITS-1:0];
      cur_v    <= s_tdata[WEIGHT_BITS+ITEM_VALUE_BITS-1:WEIGHT_BITS];
      cur_last <= s_tlast;
      cur_lim  <= lim;
    end
  end

  // read stage: entry c and entry c - weight
  assign raddr_a = walk_c;
  assign raddr_b = walk_c - AW'(cur_w);

  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl1 <= '0;
    end else begin
      ctrl1.valid   <= (state == ST_WALK);
      ctrl1.fit     <= (17'(cur_w) <= 17'(walk_c));
      ctrl1.clear   <= cur_last;
      ctrl1.capture <= cur_last && (walk_c == cur_lim);
    end
  end

  always_ff @(posedge clk) begin
    addr1 <= walk_c;
  end

  kmv_update #(
    .VALUE_BITS (VALUE_BITS)
  ) u_update (
    .ctrl       (ctrl1),
    .item_value (cur_v),
    .old_entry  (rdata_a),
    .src_entry  (rdata_b),
    .upd_entry  (upd_entry),
    .wr_data    (upd_wdata)
  );

  always_comb begin
    if (state == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_cnt;
      ram_wdata = '0;
    end else begin
      ram_we    = ctrl1.valid;
      ram_waddr = addr1;
      ram_wdata = upd_wdata;
    end
  end

  kmv_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (ROW_DEPTH)
  ) u_row (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (raddr_a),
    .rdata_a (rdata_a),
    .raddr_b (raddr_b),
    .rdata_b (rdata_b)
  );

  assign upd_ext = 64'(upd_entry);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (ctrl1.valid && ctrl1.capture) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl1.valid && ctrl1.capture) begin
      m_tdata <= upd_ext[RESULT_BITS-1:0];
    end
  end

  // a result is only produced into an empty output register
  a_capture_free: assert property (@(posedge clk) disable iff (rst)
    (ctrl1.valid && ctrl1.capture) |-> !m_tvalid)
    else $error("result captured over a pending word");

  // an accepted item always starts work
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    s_fire |=> ((state == ST_WALK) || (state == ST_HOLD)))
    else $error("accepted item did not start");

  // the update stage is empty whenever a new item can be taken
  a_drained: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !ctrl1.valid)
    else $error("row write in flight while idle");

  // a finished set leaves the high-water mark at zero
  a_hw_reset: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DRAIN && cur_last) |=> (hw == '0))
    else $error("high-water mark not cleared after last item");

endmodule
`default_nettype wire

>>> src/kmv_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module kmv_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  wire                       clk,
  input  wire                       we,
  input  wire [$clog2(DEPTH)-1:0]   waddr,
  input  wire [WIDTH-1:0]           wdata,
  input  wire [$clog2(DEPTH)-1:0]   raddr_a,
  output logic [WIDTH-1:0]          rdata_a,
  input  wire [$clog2(DEPTH)-1:0]   raddr_b,
  output logic [WIDTH-1:0]          rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule
`default_nettype wire

>>> src/kmv_update.sv
`default_nettype none
// ----------------------------------------------------------------------------
// kmv_update
// Per-entry update: best of keeping the entry or taking the item on top of
// the entry one weight lower, with saturation at the top of the value range.
// ----------------------------------------------------------------------------
module kmv_update #(
  parameter int VALUE_BITS = 32
) (
  input  kmv_pkg::kmv_ctrl_t                      ctrl,
  input  wire [kmv_pkg::ITEM_VALUE_BITS-1:0]      item_value,
  input  wire [VALUE_BITS-1:0]                    old_entry,
  input  wire [VALUE_BITS-1:0]                    src_entry,
  output logic [VALUE_BITS-1:0]                   upd_entry,
  output logic [VALUE_BITS-1:0]                   wr_data
);
  import kmv_pkg::*;

  localparam int SUM_BITS = ((VALUE_BITS > ITEM_VALUE_BITS) ? VALUE_BITS : ITEM_VALUE_BITS) + 1;
  localparam int TOP_BITS = (VALUE_BITS < RESULT_BITS) ? VALUE_BITS : RESULT_BITS;
  localparam logic [SUM_BITS-1:0] TOP = SUM_BITS'((65'd1 << TOP_BITS) - 65'd1);

  logic [SUM_BITS-1:0]   sum;
  logic [SUM_BITS-1:0]   sum_sat;
  logic [VALUE_BITS-1:0] cand;

  always_comb begin
    sum     = SUM_BITS'(src_entry) + SUM_BITS'(item_value);
    sum_sat = (sum > TOP) ? TOP : sum;
    cand    = VALUE_BITS'(sum_sat);
    upd_entry = (ctrl.fit && (cand > old_entry)) ? cand : old_entry;
    wr_data   = ctrl.clear ? '0 : upd_entry;
  end

endmodule
`default_nettype wire
